[hw/rtl/cpfm_pkg.sv]
package cpfm_pkg;

	// Fixed field widths
	localparam int PERIOD_W   = 17;
	localparam int FREQ_W     = 32;
	localparam int TOP_W      = 16;
	localparam int TPS_W      = 24;
	localparam int FRAC_W     = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;

	// Step counter of the serial divider, holds 0..FREQ_W
	localparam int DIV_CNT_W = $clog2(FREQ_W + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_TOP      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'b1;

	// Register reset values
	localparam logic [TOP_W-1:0] TOP_RESET = 16'd9999;
	localparam logic [TPS_W-1:0] TPS_RESET = 24'd1000000;

	// Divider control and status
	typedef struct packed {
		logic start;
		logic ack;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[hw/rtl/cpfm_div.sv]
// Restoring divider, one quotient bit per cycle
module cpfm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cpfm_pkg::div_ctrl_t                 ctrl,
	input  logic [cpfm_pkg::FREQ_W-1:0]         dividend,
	input  logic [cpfm_pkg::PERIOD_W-1:0]       divisor,
	output cpfm_pkg::div_stat_t                 stat,
	output logic [cpfm_pkg::FREQ_W-1:0]         quotient
);
	import cpfm_pkg::*;

	logic [PERIOD_W-1:0]  rem_q;
	logic [FREQ_W-1:0]    quo_q;
	logic [PERIOD_W-1:0]  den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W+1:0] diff;
	logic                ge;
	logic                run;

	// One trial subtraction per cycle; a zero divisor gives all ones
	assign run   = (cnt_q != '0);
	assign trial = {rem_q, quo_q[FREQ_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[PERIOD_W+1];

	// Control: step count and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (ctrl.start) begin
				cnt_q <= DIV_CNT_W'(FREQ_W);
			end else if (run) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
			if (run && cnt_q == DIV_CNT_W'(1)) begin
				done_q <= 1'b1;
			end else if (ctrl.ack) begin
				done_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[FREQ_W-2:0], ge};
		end
	end

	assign stat.busy = run;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	// Assertions
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !run && !done_q)
		else $error("divider started while busy");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(run))
		else $error("done without a division");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> run && !done_q)
		else $error("division did not begin");

endmodule

[hw/rtl/capture_period_frequency_meter_unit.sv]
// Capture period and frequency meter.
// Capture channel: capture_valid/capture_ready/capture_value, one timer
// capture per rising edge of the measured signal. Result channel:
// result_valid/result_ready with period_ticks (wrap corrected tick count
// since the previous capture) and frequency_q8 (ticks_per_second * 256 /
// period, truncated; all ones when the period comes out as zero).
// Configuration: cfg_we/cfg_index/cfg_wdata; the user must write it only
// while idle, the block does not enforce this. Index 0 is counter_top,
// index 1 is ticks_per_second. The period is formed in the accept cycle,
// the frequency by a serial divider giving one quotient bit per cycle. A
// new capture is taken only once the previous result has left the divider,
// so the divider works on one capture at a time.
// The result sits in an output register: a new capture is accepted while it
// waits. If the receiver stalls with a second result finished, the divider
// holds it and capture_ready stays low until the output register frees.
// Reset: counter_top 9999, ticks_per_second 1000000, previous capture zero,
// no result pending.
module capture_period_frequency_meter_unit #(
	parameter int CAPTURE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cpfm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cpfm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 capture_valid,
	output logic                                 capture_ready,
	input  logic [CAPTURE_WIDTH-1:0]             capture_value,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [cpfm_pkg::PERIOD_W-1:0]        period_ticks,
	output logic [cpfm_pkg::FREQ_W-1:0]          frequency_q8
);
	import cpfm_pkg::*;

	localparam int EXT_W = (CAPTURE_WIDTH > PERIOD_W) ? CAPTURE_WIDTH : PERIOD_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [TOP_W-1:0]         counter_top_q;
	logic [TPS_W-1:0]         tps_q;
	logic [CAPTURE_WIDTH-1:0] prev_q;
	logic [PERIOD_W-1:0]      period_q;
	logic [1:0]               state_q;
	logic                     result_valid_q;
	logic [PERIOD_W-1:0]      period_out_q;
	logic [FREQ_W-1:0]        freq_out_q;

	logic [EXT_W-1:0]    now_ext;
	logic [EXT_W-1:0]    prev_ext;
	logic [PERIOD_W-1:0] now_p;
	logic [PERIOD_W-1:0] prev_p;
	logic [PERIOD_W-1:0] period_d;
	logic                accept;
	logic                out_free;
	logic                xfer;
	div_ctrl_t           div_ctrl;
	div_stat_t           div_stat;
	logic [FREQ_W-1:0]   quotient;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_top_q <= TOP_RESET;
			tps_q         <= TPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COUNTER_TOP:      counter_top_q <= cfg_wdata[TOP_W-1:0];
				CFG_TICKS_PER_SECOND: tps_q         <= cfg_wdata[TPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Period: plain difference, or add the counter modulus on a wrap
	assign now_ext  = EXT_W'(capture_value);
	assign prev_ext = EXT_W'(prev_q);
	assign now_p    = now_ext[PERIOD_W-1:0];
	assign prev_p   = prev_ext[PERIOD_W-1:0];
	always_comb begin
		if (capture_value > prev_q) begin
			period_d = now_p - prev_p;
		end else begin
			period_d = {1'b0, counter_top_q} + PERIOD_W'(1) + now_p - prev_p;
		end
	end

	assign accept        = capture_valid && capture_ready;
	assign capture_ready = (state_q == ST_IDLE);
	assign out_free      = !result_valid_q || result_ready;
	assign xfer          = div_stat.done && out_free;

	assign div_ctrl.start = accept;
	assign div_ctrl.ack   = xfer;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prev_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (div_stat.done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (accept) begin
				prev_q <= capture_value;
			end
			if (xfer) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload: period travels alongside the division, then the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			period_q <= period_d;
		end
		if (xfer) begin
			period_out_q <= period_q;
			freq_out_q   <= quotient;
		end
	end

	cpfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend ({tps_q, FRAC_W'(0)}),
		.divisor  (period_d),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign result_valid = result_valid_q;
	assign period_ticks = period_out_q;
	assign frequency_q8 = freq_out_q;

	// Assertions
	a_hold_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD |-> result_valid_q && div_stat.done)
		else $error("holding a result with the output register free");
	a_run_has_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> div_stat.busy || div_stat.done)
		else $error("sequencer running with divider idle");
	a_idle_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_stat.busy && !div_stat.done)
		else $error("divider active while idle");
	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(div_stat.done))
		else $error("result without a finished division");

endmodule
